### design/button_debounce_longpress_encoder_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trigger debounce / encoder block
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONGPRESS_ENCODER_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONGPRESS_ENCODER_CORE_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define BDLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bdle: next-cycle check failed");

// consequent must hold in the same cycle as the antecedent
`define BDLE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bdle: same-cycle check failed");

`endif

### design/bdle_pkg.sv
// ----------------------------------------------------------------------------
// bdle_pkg
// Shared types and constants for the trigger debounce / encoder block.
// ----------------------------------------------------------------------------
package bdle_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned POS_W    = 32;
    localparam int unsigned MS_W     = 16;
    localparam int unsigned STEP_W   = 8;
    localparam int unsigned CODE_W   = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned S_DATA_W = 72;
    localparam int unsigned M_DATA_W = 8;

    localparam logic [MS_W-1:0]   DEBOUNCE_RESET = 16'd50;
    localparam logic [MS_W-1:0]   LONG_RESET     = 16'd1000;
    localparam logic [STEP_W-1:0] STEP_RESET     = 8'd4;

    typedef enum logic [CODE_W-1:0] {
        EV_NONE    = 3'd0,
        EV_PRESS   = 3'd1,
        EV_RELEASE = 3'd2,
        EV_LONG    = 3'd3,
        EV_CW      = 3'd4,
        EV_CCW     = 3'd5
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_LONG     = 2'd1,
        CFG_STEP     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              trigger_level;
        logic [POS_W-1:0]  encoder_pos;
    } poll_t;

    typedef struct packed {
        logic [MS_W-1:0]   debounce_ms;
        logic [MS_W-1:0]   long_press_ms;
        logic [STEP_W-1:0] encoder_step;
    } cfg_t;

endpackage

### design/button_debounce_longpress_encoder_core.sv
// ----------------------------------------------------------------------------
// button_debounce_longpress_encoder_core
// Trigger debounce with long-press detection and encoder step events.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one poll per item: tdata[31:0] now_ms,
//   tdata[32] trigger_level (0 pressed), tdata[64:33] encoder_pos.
//   m_ channel returns exactly one item per poll: tdata[2:0] event_code
//   (none, press, release, long press, clockwise, counter-clockwise).
//   Config registers (debounce, long-press time, encoder step) are written
//   through cfg_wr_en / cfg_index / cfg_wdata while the block is idle.
// Registers: the poll is loaded into the input register when accepted; the
//   event decision is loaded into the result register when the poll moves on,
//   which a held, untaken result can delay.
// Throughput: one poll per cycle while m_tready is high; the event unit
//   updates by combinational subtract-and-compare, so polls go back to back.
// Reset: aresetn low empties both registers and returns the trigger state to
//   released, timers and encoder base to zero, config to its defaults.
// Stall: while m_tready is low the result holds; one more poll waits in the
//   input register, and s_tready drops once both are full.
// ----------------------------------------------------------------------------
`include "button_debounce_longpress_encoder_core_assert.svh"

module button_debounce_longpress_encoder_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [31:0] now_ms, [32] trigger_level, [64:33] encoder_pos, [71:65] zero
    input  logic [bdle_pkg::S_DATA_W-1:0]        s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [2:0] event_code, [7:3] zero
    output logic [bdle_pkg::M_DATA_W-1:0]        m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [bdle_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bdle_pkg::MS_W-1:0]            cfg_wdata
);

    bdle_pkg::cfg_t   cfg_reg;
    bdle_pkg::cfg_t   cfg_next;
    logic             out_valid_reg, out_valid_next;
    bdle_pkg::event_t out_code_reg;
    bdle_pkg::event_t code;
    bdle_pkg::poll_t  item;
    logic             item_valid;
    logic             advance;

    assign advance  = item_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(bdle_pkg::M_DATA_W-bdle_pkg::CODE_W){1'b0}}, out_code_reg};

    bdle_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bdle_event_unit u_event (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (item),
        .cfg     (cfg_reg),
        .code    (code)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                bdle_pkg::CFG_DEBOUNCE: cfg_next.debounce_ms   = cfg_wdata;
                bdle_pkg::CFG_LONG:     cfg_next.long_press_ms = cfg_wdata;
                bdle_pkg::CFG_STEP:     cfg_next.encoder_step  = cfg_wdata[bdle_pkg::STEP_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms   <= bdle_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_ms <= bdle_pkg::LONG_RESET;
            cfg_reg.encoder_step  <= bdle_pkg::STEP_RESET;
            out_valid_reg         <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register: load the decision when the poll moves on
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_code_reg <= code;
        end
    end

    `BDLE_ASSERT_NEXT(a_item_moves, advance, out_valid_reg)
    `BDLE_ASSERT_NEXT(a_item_waits, item_valid && !advance, item_valid)
    `BDLE_ASSERT_SAME(a_ready_when_drain, item_valid && out_valid_reg && m_tready, s_tready)

endmodule

### design/bdle_in_reg.sv
// ----------------------------------------------------------------------------
// bdle_in_reg
// Input register: captures one poll item and holds it until the event unit
// takes it.
// ----------------------------------------------------------------------------
module bdle_in_reg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bdle_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                              advance,
    output logic                              item_valid,
    output bdle_pkg::poll_t                   item
);

    logic            valid_reg;
    logic            valid_next;
    bdle_pkg::poll_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.now_ms        <= s_tdata[31:0];
            item_reg.trigger_level <= s_tdata[32];
            item_reg.encoder_pos   <= s_tdata[64:33];
        end
    end

endmodule

### design/bdle_event_unit.sv
// ----------------------------------------------------------------------------
// bdle_event_unit
// Debounce, long-press and encoder state with the per-poll event decision.
// ----------------------------------------------------------------------------
`include "button_debounce_longpress_encoder_core_assert.svh"

module bdle_event_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  bdle_pkg::poll_t      item,
    input  bdle_pkg::cfg_t       cfg,
    output bdle_pkg::event_t     code
);

    logic                          last_raw_reg, last_raw_next;
    logic                          stable_reg, stable_next;
    logic [bdle_pkg::TIME_W-1:0]   db_start_reg, db_start_next;
    logic [bdle_pkg::TIME_W-1:0]   press_start_reg, press_start_next;
    logic                          long_done_reg, long_done_next;
    logic [bdle_pkg::POS_W-1:0]    base_reg, base_next;

    logic                          raw_changed;
    logic [bdle_pkg::TIME_W-1:0]   db_elapsed;
    logic [bdle_pkg::TIME_W-1:0]   press_elapsed;
    logic [bdle_pkg::POS_W-1:0]    udiff;
    logic [bdle_pkg::POS_W-1:0]    mag;
    logic [bdle_pkg::STEP_W-1:0]   step_eff;
    logic                          trig_event;
    logic                          long_event;
    logic                          enc_event;

    always_comb begin
        raw_changed   = item.trigger_level != last_raw_reg;
        // a raw change restarts the timer, so elapsed is zero in that poll
        db_elapsed    = raw_changed ? '0 : (item.now_ms - db_start_reg);
        press_elapsed = item.now_ms - press_start_reg;
        udiff         = item.encoder_pos - base_reg;
        mag           = udiff[bdle_pkg::POS_W-1] ? ('0 - udiff) : udiff;
        step_eff      = (cfg.encoder_step == '0) ? bdle_pkg::STEP_W'(1) : cfg.encoder_step;

        trig_event = (db_elapsed > {{(bdle_pkg::TIME_W-bdle_pkg::MS_W){1'b0}}, cfg.debounce_ms})
                     && (item.trigger_level != stable_reg);
        long_event = !stable_reg && !long_done_reg
                     && (press_elapsed >
                         {{(bdle_pkg::TIME_W-bdle_pkg::MS_W){1'b0}}, cfg.long_press_ms});
        enc_event  = mag >= {{(bdle_pkg::POS_W-bdle_pkg::STEP_W){1'b0}}, step_eff};

        last_raw_next    = last_raw_reg;
        stable_next      = stable_reg;
        db_start_next    = db_start_reg;
        press_start_next = press_start_reg;
        long_done_next   = long_done_reg;
        base_next        = base_reg;

        if (trig_event) begin
            code = item.trigger_level ? bdle_pkg::EV_RELEASE : bdle_pkg::EV_PRESS;
        end else if (long_event) begin
            code = bdle_pkg::EV_LONG;
        end else if (enc_event) begin
            code = udiff[bdle_pkg::POS_W-1] ? bdle_pkg::EV_CCW : bdle_pkg::EV_CW;
        end else begin
            code = bdle_pkg::EV_NONE;
        end

        if (fire) begin
            last_raw_next = item.trigger_level;
            if (raw_changed) begin
                db_start_next = item.now_ms;
            end
            if (trig_event) begin
                stable_next = item.trigger_level;
                if (!item.trigger_level) begin
                    press_start_next = item.now_ms;
                    long_done_next   = 1'b0;
                end
            end else if (long_event) begin
                long_done_next = 1'b1;
            end else if (enc_event) begin
                base_next = item.encoder_pos;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg    <= 1'b1;
            stable_reg      <= 1'b1;
            db_start_reg    <= '0;
            press_start_reg <= '0;
            long_done_reg   <= 1'b0;
            base_reg        <= '0;
        end else begin
            last_raw_reg    <= last_raw_next;
            stable_reg      <= stable_next;
            db_start_reg    <= db_start_next;
            press_start_reg <= press_start_next;
            long_done_reg   <= long_done_next;
            base_reg        <= base_next;
        end
    end

    `BDLE_ASSERT_NEXT(a_press_arms, fire && code == bdle_pkg::EV_PRESS, !stable_reg && !long_done_reg)
    `BDLE_ASSERT_NEXT(a_long_once, fire && code == bdle_pkg::EV_LONG, long_done_reg && !stable_reg)
    `BDLE_ASSERT_NEXT(a_release_stable, fire && code == bdle_pkg::EV_RELEASE, stable_reg)
    `BDLE_ASSERT_SAME(a_long_needs_press, code == bdle_pkg::EV_LONG, !stable_reg)

endmodule
